// ===== rtl/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg
// shared types and constants of the piecewise linear interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  localparam int unsigned POS_W   = 20;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned DIFF_W  = VAL_W + 1;
  localparam int unsigned PROD_W  = POS_W + VAL_W;
  localparam int unsigned MUL_STEPS = POS_W;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned STEP_W  = 6;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_TOO_FEW = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] disp;
    logic signed [VAL_W-1:0] tens;
  } entry_t;

  // one interpolation request: offset into the segment, its length, end values
  typedef struct packed {
    logic [POS_W-1:0]        off;
    logic [POS_W-1:0]        span;
    logic signed [VAL_W-1:0] v0;
    logic signed [VAL_W-1:0] v1;
  } lerp_req_t;

endpackage

`default_nettype wire

// ===== rtl/piecewise_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// breakpoint table with clear, append and interpolating query
// ----------------------------------------------------------------------------
// clear and append: result strobed in the cycle after the request, no busy time
// query: one segment per cycle from the single table read port, then a 20-step
//   serial multiply and 52-step serial divide for a match; a zero-length matching
//   segment skips both, and a miss over all points ends the scan with status outside
// the receiver cannot stall; results are strobed for one cycle on done_o
// reset empties the table (point count zero); table contents are not cleared
`default_nettype none

module piecewise_linear_interpolator #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic [1:0]                           command_i,
  input  wire logic signed [pli_pkg::POS_W-1:0]     position_i,
  input  wire logic signed [pli_pkg::VAL_W-1:0]     displacement_in_i,
  input  wire logic signed [pli_pkg::VAL_W-1:0]     tension_in_i,
  output logic                                      done_o,
  output logic [1:0]                                status_o,
  output logic signed [pli_pkg::VAL_W-1:0]          displacement_out_o,
  output logic signed [pli_pkg::VAL_W-1:0]          tension_out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_LERP
  } state_e;

  state_e                           state_q;
  logic [CNT_W-1:0]                 count_q;
  logic [IDX_W-1:0]                 idx_q;
  logic signed [pli_pkg::POS_W-1:0] pos_q;
  pli_pkg::entry_t                  prev_q;
  logic                             done_q;
  logic [1:0]                       status_q;
  logic signed [pli_pkg::VAL_W-1:0] disp_q;
  logic signed [pli_pkg::VAL_W-1:0] tens_q;

  pli_pkg::entry_t                  mem [MAX_POINTS];
  pli_pkg::entry_t                  rdata_q;
  logic                             mem_we;
  logic                             mem_re;
  logic [IDX_W-1:0]                 mem_raddr;
  pli_pkg::entry_t                  wentry;

  logic                             accept;
  logic                             match;
  logic                             last_seg;
  logic [pli_pkg::POS_W:0]          off_wide;
  logic [pli_pkg::POS_W:0]          span_wide;
  logic                             lerp_start;
  pli_pkg::lerp_req_t               req_disp;
  pli_pkg::lerp_req_t               req_tens;
  logic                             done_disp;
  logic                             done_tens;
  logic signed [pli_pkg::VAL_W-1:0] res_disp;
  logic signed [pli_pkg::VAL_W-1:0] res_tens;

  always_comb begin
    accept    = start_i && (state_q == S_IDLE);
    match     = (pos_q >= prev_q.pos) && (pos_q <= rdata_q.pos);
    last_seg  = (CNT_W'(idx_q) == count_q - CNT_W'(1));
    off_wide  = {pos_q[pli_pkg::POS_W-1], pos_q} - {prev_q.pos[pli_pkg::POS_W-1], prev_q.pos};
    span_wide = {rdata_q.pos[pli_pkg::POS_W-1], rdata_q.pos}
              - {prev_q.pos[pli_pkg::POS_W-1], prev_q.pos};
    lerp_start = (state_q == S_SCAN) && match;

    req_disp.off  = off_wide[pli_pkg::POS_W-1:0];
    req_disp.span = span_wide[pli_pkg::POS_W-1:0];
    req_disp.v0   = prev_q.disp;
    req_disp.v1   = rdata_q.disp;
    req_tens.off  = off_wide[pli_pkg::POS_W-1:0];
    req_tens.span = span_wide[pli_pkg::POS_W-1:0];
    req_tens.v0   = prev_q.tens;
    req_tens.v1   = rdata_q.tens;

    wentry.pos  = position_i;
    wentry.disp = displacement_in_i;
    wentry.tens = tension_in_i;

    mem_we    = accept && (command_i == pli_pkg::CMD_APPEND)
             && (count_q < CNT_W'(MAX_POINTS));
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      S_IDLE: begin
        mem_re = accept && (command_i == pli_pkg::CMD_QUERY) && (count_q >= CNT_W'(2));
      end
      S_FIRST: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q + 1'b1;
      end
      S_SCAN: begin
        mem_re    = !match && !last_seg;
        mem_raddr = idx_q + 1'b1;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // breakpoint table, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IDX_W-1:0]] <= wentry;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_q <= pli_pkg::ST_OK;
            disp_q   <= '0;
            tens_q   <= '0;
            case (command_i)
              pli_pkg::CMD_CLEAR: begin
                count_q <= '0;
                done_q  <= 1'b1;
              end
              pli_pkg::CMD_APPEND: begin
                done_q <= 1'b1;
                if (count_q < CNT_W'(MAX_POINTS)) begin
                  count_q <= count_q + 1'b1;
                end else begin
                  status_q <= pli_pkg::ST_FULL;
                end
              end
              pli_pkg::CMD_QUERY: begin
                if (count_q < CNT_W'(2)) begin
                  status_q <= pli_pkg::ST_TOO_FEW;
                  done_q   <= 1'b1;
                end else begin
                  pos_q   <= position_i;
                  idx_q   <= '0;
                  state_q <= S_FIRST;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_FIRST: begin
          prev_q  <= rdata_q;
          idx_q   <= idx_q + 1'b1;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          // rdata_q holds entry idx_q, prev_q entry idx_q - 1
          if (match) begin
            state_q <= S_LERP;
          end else if (last_seg) begin
            status_q <= pli_pkg::ST_OUTSIDE;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            prev_q <= rdata_q;
            idx_q  <= idx_q + 1'b1;
          end
        end
        S_LERP: begin
          if (done_disp && done_tens) begin
            status_q <= pli_pkg::ST_OK;
            disp_q   <= res_disp;
            tens_q   <= res_tens;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  pli_lerp u_lerp_disp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lerp_start),
    .req_i    (req_disp),
    .done_o   (done_disp),
    .result_o (res_disp)
  );

  pli_lerp u_lerp_tens (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lerp_start),
    .req_i    (req_tens),
    .done_o   (done_tens),
    .result_o (res_tens)
  );

  assign busy_o             = (state_q != S_IDLE);
  assign done_o             = done_q;
  assign status_o           = status_q;
  assign displacement_out_o = disp_q;
  assign tension_out_o      = tens_q;

endmodule

`default_nettype wire

// ===== rtl/pli_lerp.sv =====
// ----------------------------------------------------------------------------
// pli_lerp
// bit-serial v0 + off * (v1 - v0) / span, truncating toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module pli_lerp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire pli_pkg::lerp_req_t               req_i,
  output logic                                  done_o,
  output logic signed [pli_pkg::VAL_W-1:0]      result_o
);

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_FIN
  } lerp_state_e;

  lerp_state_e                       state_q;
  logic                              done_q;
  logic signed [pli_pkg::VAL_W-1:0]  result_q;
  logic signed [pli_pkg::VAL_W-1:0]  v0_q;
  logic                              neg_q;
  logic [pli_pkg::DIFF_W-1:0]        mag_q;
  logic [pli_pkg::POS_W-1:0]         off_q;
  logic [pli_pkg::POS_W-1:0]         span_q;
  logic [pli_pkg::PROD_W-1:0]        acc_q;
  logic [pli_pkg::POS_W-1:0]         rem_q;
  logic [pli_pkg::STEP_W-1:0]        cnt_q;

  logic signed [pli_pkg::DIFF_W-1:0] diff;
  logic [pli_pkg::DIFF_W-1:0]        mag_d;
  logic [pli_pkg::POS_W:0]           shifted;
  logic [pli_pkg::POS_W+1:0]         trial;
  logic                              borrow;
  logic [pli_pkg::DIFF_W-1:0]        quot;
  logic [pli_pkg::DIFF_W-1:0]        quot_signed;
  logic signed [pli_pkg::VAL_W-1:0]  result_d;

  always_comb begin
    diff    = pli_pkg::DIFF_W'(req_i.v1) - pli_pkg::DIFF_W'(req_i.v0);
    mag_d   = diff[pli_pkg::DIFF_W-1] ? (pli_pkg::DIFF_W'(0) - diff) : diff;
    // restoring division step, quotient bits shift in behind the dividend
    shifted = {rem_q, acc_q[pli_pkg::PROD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, span_q};
    borrow  = trial[pli_pkg::POS_W+1];
    quot    = acc_q[pli_pkg::DIFF_W-1:0];
    quot_signed = neg_q ? (pli_pkg::DIFF_W'(0) - quot) : quot;
    result_d = v0_q + quot_signed[pli_pkg::VAL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            v0_q   <= req_i.v0;
            neg_q  <= diff[pli_pkg::DIFF_W-1];
            mag_q  <= mag_d;
            off_q  <= req_i.off;
            span_q <= req_i.span;
            acc_q  <= '0;
            rem_q  <= '0;
            cnt_q  <= '0;
            if (req_i.span == '0) begin
              // zero-length segment gives its start value
              result_q <= req_i.v0;
              done_q   <= 1'b1;
            end else begin
              state_q <= L_MUL;
            end
          end
        end
        L_MUL: begin
          acc_q <= {acc_q[pli_pkg::PROD_W-2:0], 1'b0}
                 + (off_q[pli_pkg::POS_W-1] ? pli_pkg::PROD_W'(mag_q) : '0);
          off_q <= {off_q[pli_pkg::POS_W-2:0], 1'b0};
          if (cnt_q == pli_pkg::STEP_W'(pli_pkg::MUL_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= L_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        L_DIV: begin
          acc_q <= {acc_q[pli_pkg::PROD_W-2:0], ~borrow};
          rem_q <= borrow ? shifted[pli_pkg::POS_W-1:0] : trial[pli_pkg::POS_W-1:0];
          if (cnt_q == pli_pkg::STEP_W'(pli_pkg::DIV_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= L_FIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        L_FIN: begin
          result_q <= result_d;
          done_q   <= 1'b1;
          state_q  <= L_IDLE;
        end
        default: begin
          state_q <= L_IDLE;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_piecewise_linear_interpolator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_interpolator
// self-checking bench for the breakpoint table and interpolating query
// ----------------------------------------------------------------------------
// a shadow table predicts status, displacement and tension for every accepted
// request; strobed results are checked in order against the oldest prediction.
// directed requests cover empty and single-point tables, extreme positions and
// values, zero-length and descending segments and the unused command; random
// phases then build mostly sorted tables (one phase in six overfills the table) and
// query inside, on and outside the breakpoints, mixed with stray requests
// ----------------------------------------------------------------------------

module tb_piecewise_linear_interpolator;

  localparam int          TABLE_DEPTH = 64;
  localparam int          ITEM_TARGET = 650;
  localparam int          IDLE_LIMIT  = 3000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] disp;
    logic signed [31:0] tens;
  } interp_result_t;

  // shadow of the breakpoint table and the results still owed by the block
  class lerp_table_model;
    int             count;
    int             tbl_pos[TABLE_DEPTH];
    int             tbl_disp[TABLE_DEPTH];
    int             tbl_tens[TABLE_DEPTH];
    interp_result_t awaited[$];
    int             mismatches;

    function new();
      count      = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // exact product, quotient truncated toward zero
    function logic signed [31:0] blend(int off, int span, int v0, int v1);
      longint r;
      if (span == 0) begin
        r = longint'(v0);
      end else begin
        r = longint'(v0) + (longint'(off) * (longint'(v1) - longint'(v0))) / longint'(span);
      end
      return r[31:0];
    endfunction

    function void take_request(logic [1:0] cmd, logic signed [19:0] pos,
                               logic signed [31:0] d, logic signed [31:0] t);
      interp_result_t r;
      int             q;
      int             i;
      bit             hit;
      r.status = pli_pkg::ST_OK;
      r.disp   = '0;
      r.tens   = '0;
      q        = int'(pos);
      hit      = 1'b0;
      case (cmd)
        pli_pkg::CMD_CLEAR: begin
          count = 0;
        end
        pli_pkg::CMD_APPEND: begin
          if (count >= TABLE_DEPTH) begin
            r.status = pli_pkg::ST_FULL;
          end else begin
            tbl_pos[count]  = q;
            tbl_disp[count] = d;
            tbl_tens[count] = t;
            count++;
          end
        end
        pli_pkg::CMD_QUERY: begin
          if (count < 2) begin
            r.status = pli_pkg::ST_TOO_FEW;
          end else begin
            // first segment that holds the position wins; descending ones never do
            for (i = 0; i + 1 < count && !hit; i++) begin
              if (q >= tbl_pos[i] && q <= tbl_pos[i+1]) begin
                hit    = 1'b1;
                r.disp = blend(q - tbl_pos[i], tbl_pos[i+1] - tbl_pos[i],
                               tbl_disp[i], tbl_disp[i+1]);
                r.tens = blend(q - tbl_pos[i], tbl_pos[i+1] - tbl_pos[i],
                               tbl_tens[i], tbl_tens[i+1]);
              end
            end
            if (!hit) r.status = pli_pkg::ST_OUTSIDE;
          end
        end
        default: ;
      endcase
      awaited.insert(awaited.size(), r);
    endfunction

    function void check_output(logic [1:0] st, logic signed [31:0] d, logic signed [31:0] t);
      interp_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result status %0d displacement %0d tension %0d",
                 $time, st, d, t);
        mismatches++;
        return;
      end
      e = awaited[0];
      awaited.delete(0);
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        mismatches++;
      end
      if (d !== e.disp) begin
        $display("%0t: displacement expected %0d actual %0d", $time, e.disp, d);
        mismatches++;
      end
      if (t !== e.tens) begin
        $display("%0t: tension expected %0d actual %0d", $time, e.tens, t);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         command_i;
  logic signed [19:0] position_i;
  logic signed [31:0] displacement_in_i;
  logic signed [31:0] tension_in_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] displacement_out_o;
  logic signed [31:0] tension_out_o;

  lerp_table_model model;
  int              items_sent = 0;
  int              burst_left = 0;
  int              idle_cycles = 0;
  int              phase;

  piecewise_linear_interpolator #(
    .MAX_POINTS(TABLE_DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .command_i          (command_i),
    .position_i         (position_i),
    .displacement_in_i  (displacement_in_i),
    .tension_in_i       (tension_in_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .displacement_out_o (displacement_out_o),
    .tension_out_o      (tension_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) model.check_output(status_o, displacement_out_o, tension_out_o);
  end

  // nothing accepted on either side for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_val();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 2000) - 1000;
    return $urandom();
  endfunction

  // present one request, holding it until the block takes it; bursts with gaps
  task automatic issue(input logic [1:0] cmd, input int pos, input int d, input int t);
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
    end
    start_i           <= 1'b1;
    command_i         <= cmd;
    position_i        <= 20'(pos);
    displacement_in_i <= d;
    tension_in_i      <= t;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    model.take_request(cmd, 20'(pos), d, t);
    items_sent++;
    burst_left--;
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (model.pending() != 0);
  endtask

  // clear, build a mostly sorted table, then query it
  task automatic run_phase(input int idx);
    int pts[$];
    int npts;
    int stride;
    int p;
    int lo;
    int hi;
    int nq;
    int pick;
    int q;
    if (idx % 4 == 3) wait_idle();
    issue(pli_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom());
    if ($urandom_range(0, 3) == 0) issue(pli_pkg::CMD_QUERY, $urandom(), $urandom(), $urandom());
    npts   = (idx % 6 == 2) ? TABLE_DEPTH + $urandom_range(1, 3) : $urandom_range(2, 12);
    stride = ($urandom_range(0, 2) == 0) ? 8 : 1048575 / npts;
    p      = $urandom_range(0, 1048575 - npts * stride);
    p      = p - 524288;
    for (int k = 0; k < npts; k++) begin
      if (k > 0) p = p + $urandom_range(0, stride);
      // the odd stray point leaves a descending segment behind
      if ($urandom_range(0, 9) == 0) begin
        q = $urandom_range(0, 1048575) - 524288;
      end else begin
        q = p;
      end
      pts.insert(pts.size(), q);
      issue(pli_pkg::CMD_APPEND, q, rand_val(), rand_val());
    end
    lo = pts[0];
    hi = pts[pts.size()-1];
    if (hi < lo) begin
      q  = lo;
      lo = hi;
      hi = q;
    end
    nq = $urandom_range(2, 12);
    for (int k = 0; k < nq; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        q = $urandom_range(0, hi - lo);
        issue(pli_pkg::CMD_QUERY, lo + q, $urandom(), $urandom());
      end else if (pick < 17) begin
        issue(pli_pkg::CMD_QUERY, pts[$urandom_range(0, pts.size() - 1)],
              $urandom(), $urandom());
      end else if (pick < 18) begin
        issue(pli_pkg::CMD_APPEND, $urandom(), rand_val(), rand_val());
      end else if (pick < 19) begin
        issue(CMD_UNUSED, $urandom(), $urandom(), $urandom());
      end else begin
        issue(pli_pkg::CMD_QUERY, $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    model             = new();
    rst_ni            <= 1'b0;
    start_i           <= 1'b0;
    command_i         <= pli_pkg::CMD_CLEAR;
    position_i        <= '0;
    displacement_in_i <= '0;
    tension_in_i      <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty and single-point tables, then full-range extremes
    issue(pli_pkg::CMD_QUERY, 0, 0, 0);
    issue(pli_pkg::CMD_APPEND, -524288, 32'sh8000_0000, 32'sh7fff_ffff);
    issue(pli_pkg::CMD_QUERY, -524288, 0, 0);
    issue(pli_pkg::CMD_APPEND, 524287, 32'sh7fff_ffff, 32'sh8000_0000);
    issue(pli_pkg::CMD_QUERY, -524288, 0, 0);
    issue(pli_pkg::CMD_QUERY, 524287, 0, 0);
    issue(pli_pkg::CMD_QUERY, 0, 0, 0);
    issue(pli_pkg::CMD_QUERY, -1, 32'shffff_ffff, 32'shffff_ffff);
    issue(CMD_UNUSED, 524287, 32'shffff_ffff, 32'shffff_ffff);
    issue(pli_pkg::CMD_CLEAR, -1, 32'shffff_ffff, 32'shffff_ffff);
    issue(pli_pkg::CMD_QUERY, 5, 0, 0);
    // zero-length first segment, then a descending one
    issue(pli_pkg::CMD_APPEND, 100, 32'sh000a_0000, -32'sh0003_0000);
    issue(pli_pkg::CMD_APPEND, 100, 32'sh0014_0000, 32'sh0007_8000);
    issue(pli_pkg::CMD_APPEND, 200, -32'sh0001_4000, 32'sh0100_0000);
    issue(pli_pkg::CMD_APPEND, 50, 32'sh0000_0001, -32'sh0000_0001);
    issue(pli_pkg::CMD_APPEND, 300, 32'sh0123_4567, -32'sh0765_4321);
    issue(pli_pkg::CMD_QUERY, 100, 0, 0);
    issue(pli_pkg::CMD_QUERY, 150, 0, 0);
    issue(pli_pkg::CMD_QUERY, 40, 0, 0);
    issue(pli_pkg::CMD_QUERY, 60, 0, 0);
    issue(pli_pkg::CMD_QUERY, 300, 0, 0);
    issue(pli_pkg::CMD_QUERY, 301, 0, 0);
    issue(pli_pkg::CMD_QUERY, -1, 0, 0);
    wait_idle();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase);
      phase++;
    end

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (model.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
